// ----- hw/rtl/stsa_pkg.sv -----
// Shared types and constants of the sorted sparse tile allocator.
// No dependencies; imported by stsa_core and sorted_sparse_tile_allocator.
package stsa_pkg;

    localparam int KEY_W       = 16;
    localparam int COL_W       = 8;
    localparam int ROW_W       = 8;
    localparam int OP_W        = 2;
    localparam int SLOT_OUT_W  = 5;
    localparam int TILE_W      = 8;
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ALLOC = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_KEYRD,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_DR_CHK,
        S_DR_KEY,
        S_DR_CMP,
        S_DR_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  found_existing;
        logic                  table_full;
        logic                  patch_valid;
        logic [COL_W-1:0]      patch_col;
        logic [TILE_W-1:0]     patch_tile;
        logic                  last;
    } t_result;

endpackage

// ----- hw/rtl/stsa_core.sv -----
// Sequencer, key/order memories and shared key comparator of the allocator.
// Depends on stsa_pkg; instantiated by sorted_sparse_tile_allocator.
module stsa_core
    import stsa_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_op               i_op,
    input  logic [COL_W-1:0]  i_col,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [TILE_W-1:0] i_tile_base,
    output logic              o_busy,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_ready
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    t_state r_state, n_state;

    logic [KEY_W-1:0] key_mem [SLOT_COUNT];
    logic [IW-1:0]    ord_mem [SLOT_COUNT];

    logic [KEY_W-1:0]     r_key_q;
    logic [IW-1:0]        r_ord_q;
    logic [KEY_W-1:0]     r_key,   n_key;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_rpos,  n_rpos;
    logic [CW-1:0]        r_lo,    n_lo;
    logic [CW-1:0]        r_hi,    n_hi;
    logic [CW-1:0]        r_mid,   n_mid;
    logic [CW-1:0]        r_k,     n_k;
    logic [IW-1:0]        r_hit,   n_hit;
    logic [RES_CNT_W-1:0] r_n,     n_n;
    logic                 r_pend,  n_pend;
    t_result              r_res,   n_res;

    // memory controls
    logic             ord_re, ord_we, key_re, key_we;
    logic [IW-1:0]    ord_raddr, ord_waddr, ord_wdata, key_raddr, key_waddr;

    // shared comparator and search arithmetic
    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid;
    logic             lo_lt_hi, lo_lt_cnt, key_lt, key_eq, row_eq, full, dr_more;
    logic [IW+SLOT_OUT_W-1:0] hit_ext, cnt_ext;
    logic [IW+TILE_W-1:0]     tile_ext;

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[CW:1];
    assign lo_lt_hi  = r_lo < r_hi;
    assign lo_lt_cnt = r_lo < r_count;
    assign key_lt    = r_key_q < r_key;
    assign key_eq    = r_key_q == r_key;
    assign row_eq    = r_key_q[KEY_W-1:COL_W] == r_key[KEY_W-1:COL_W];
    assign full      = r_count == CW'(SLOT_COUNT);
    assign dr_more   = (r_rpos < r_count) && (r_n < RES_CNT_W'(MAX_RESULTS));
    assign hit_ext   = {{SLOT_OUT_W{1'b0}}, r_hit};
    assign cnt_ext   = {{SLOT_OUT_W{1'b0}}, r_count[IW-1:0]};
    assign tile_ext  = {{TILE_W{1'b0}}, r_hit};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_op)
                        OP_ALLOC: n_state = full ? S_EMIT : S_SRCH;
                        OP_DRAIN: n_state = S_DR_CHK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SRCH:   n_state = (lo_lt_hi || lo_lt_cnt) ? S_KEYRD : S_SHRD;
            S_KEYRD:  n_state = S_CMP;
            S_CMP: begin
                if (lo_lt_hi) n_state = S_SRCH;
                else          n_state = key_eq ? S_EMIT : S_SHRD;
            end
            S_SHRD:   n_state = (r_k > r_lo) ? S_SHWR : S_EMIT;
            S_SHWR:   n_state = S_SHRD;
            S_DR_CHK: n_state = dr_more ? S_DR_KEY : S_DR_FIN;
            S_DR_KEY: n_state = S_DR_CMP;
            S_DR_CMP: begin
                if (!row_eq)                        n_state = S_DR_FIN;
                else if (!r_pend || i_res_ready)    n_state = S_DR_CHK;
                else                                n_state = S_DR_CMP;
            end
            S_DR_FIN: n_state = S_EMIT;
            S_EMIT:   n_state = i_res_ready ? S_IDLE : S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs: memory strobes, result beat, busy
    always_comb begin
        ord_re      = 1'b0;
        ord_raddr   = '0;
        ord_we      = 1'b0;
        ord_waddr   = '0;
        ord_wdata   = '0;
        key_re      = 1'b0;
        key_raddr   = r_ord_q;
        key_we      = 1'b0;
        key_waddr   = r_count[IW-1:0];
        o_res_valid = 1'b0;
        o_busy      = r_state != S_IDLE;
        case (r_state)
            S_SRCH: begin
                ord_re    = lo_lt_hi || lo_lt_cnt;
                ord_raddr = lo_lt_hi ? mid[IW-1:0] : r_lo[IW-1:0];
            end
            S_KEYRD,
            S_DR_KEY: key_re = 1'b1;
            S_SHRD: begin
                if (r_k > r_lo) begin
                    ord_re    = 1'b1;
                    ord_raddr = IW'(r_k - CW'(1));
                end else begin
                    // drop the new slot into its lower-bound place
                    ord_we    = 1'b1;
                    ord_waddr = r_lo[IW-1:0];
                    ord_wdata = r_count[IW-1:0];
                    key_we    = 1'b1;
                end
            end
            S_SHWR: begin
                ord_we    = 1'b1;
                ord_waddr = r_k[IW-1:0];
                ord_wdata = r_ord_q;
            end
            S_DR_CHK: begin
                ord_re    = dr_more;
                ord_raddr = r_rpos[IW-1:0];
            end
            S_DR_CMP: o_res_valid = row_eq && r_pend;
            S_EMIT:   o_res_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        n_rpos  = r_rpos;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_k     = r_k;
        n_hit   = r_hit;
        n_n     = r_n;
        n_pend  = r_pend;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key  = {i_row, i_col};
                    n_lo   = '0;
                    n_hi   = r_count;
                    n_k    = r_count;
                    n_n    = '0;
                    n_pend = 1'b0;
                    n_res  = '0;
                    n_res.last = 1'b1;
                    if (i_op == OP_CLEAR) begin
                        n_count = '0;
                        n_rpos  = '0;
                    end
                    if (i_op == OP_ALLOC && full) n_res.table_full = 1'b1;
                end
            end
            S_SRCH:  n_mid = lo_lt_hi ? mid : r_lo;
            S_KEYRD: n_hit = r_ord_q;
            S_CMP: begin
                if (lo_lt_hi) begin
                    if (key_lt) n_lo = r_mid + CW'(1);
                    else        n_hi = r_mid;
                end else if (key_eq) begin
                    n_res.slot           = hit_ext[SLOT_OUT_W-1:0];
                    n_res.found_existing = 1'b1;
                end else begin
                    n_k = r_count;
                end
            end
            S_SHRD: begin
                if (!(r_k > r_lo)) begin
                    n_res.slot = cnt_ext[SLOT_OUT_W-1:0];
                    n_count    = r_count + CW'(1);
                end
            end
            S_SHWR:   n_k = r_k - CW'(1);
            S_DR_KEY: n_hit = r_ord_q;
            S_DR_CMP: begin
                if (row_eq && (!r_pend || i_res_ready)) begin
                    n_res             = '0;
                    n_res.patch_valid = 1'b1;
                    n_res.patch_col   = r_key_q[COL_W-1:0];
                    n_res.patch_tile  = i_tile_base + tile_ext[TILE_W-1:0];
                    n_pend            = 1'b1;
                    n_rpos            = r_rpos + CW'(1);
                    n_n               = r_n + RES_CNT_W'(1);
                end
            end
            S_DR_FIN: begin
                // flag the held entry as final, or emit the no-match marker
                if (!r_pend) n_res = '0;
                n_res.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rpos  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rpos  <= n_rpos;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_k   <= n_k;
        r_hit <= n_hit;
        r_n   <= n_n;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
        if (ord_re) r_ord_q <= ord_mem[ord_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[key_waddr] <= r_key;
        if (key_re) r_key_q <= key_mem[key_raddr];
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/sorted_sparse_tile_allocator.sv -----
// Top level of the sorted sparse tile allocator: handshakes, tile base
// register and output register around stsa_core. Depends on stsa_pkg.
//
// Keeps up to SLOT_COUNT tile slots keyed by {row, col}, ordered through an
// order list. Allocate (op 1) binary-searches the list: a present key
// returns its slot with found_existing set, a new key takes the next free
// slot and is inserted by shifting the list up one entry at a time; a full
// table answers table_full. Drain (op 2) walks the list from the read
// pointer and returns every consecutive entry of the given row (at most 32
// per item) as column plus tile number (tile_base + slot, mod 256), last
// set on the final one; with no match it returns one beat with
// patch_valid clear. Clear (op 0) empties the table, op 3 does nothing;
// neither returns a beat. One item is worked at a time and o_in_stall is
// high until its last beat has entered the output register. Every memory
// access goes through a registered read port, so one search step is an order
// read, a key read and a compare; an insert moves each entry above the
// insertion point with a read state and a write state, and a drain reads
// the order entry, then its key, then compares, for each entry that it
// returns. The output register takes a beat while the previous one is being
// taken. tile_base is to be written by the user through i_cfg_we/i_cfg_data
// only while the block is idle; the block has no check for this. Neither
// store needs a clearing pass after reset.
module sorted_sparse_tile_allocator
    import stsa_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [TILE_W-1:0]     i_cfg_data,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [COL_W-1:0]      i_col,
    input  logic [ROW_W-1:0]      i_row,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLOT_OUT_W-1:0] o_slot,
    output logic                  o_found_existing,
    output logic                  o_table_full,
    output logic                  o_patch_valid,
    output logic [COL_W-1:0]      o_patch_col,
    output logic [TILE_W-1:0]     o_patch_tile,
    output logic                  o_last
);

    logic [TILE_W-1:0] r_tile_base;
    logic              r_out_valid;
    t_result           r_out;

    logic    busy, start, res_valid, res_ready;
    t_result res;

    // take a new item only while the sequencer is idle
    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;

    // the output register frees up in the cycle its beat is taken
    assign res_ready  = !r_out_valid || !i_out_stall;

    stsa_core #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (t_op'(i_op)),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_tile_base (r_tile_base),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_base <= '0;
        end else if (i_cfg_we) begin
            r_tile_base <= i_cfg_data;
        end
    end

    // output register: load a new beat, drop a taken one, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_slot           = r_out.slot;
    assign o_found_existing = r_out.found_existing;
    assign o_table_full     = r_out.table_full;
    assign o_patch_valid    = r_out.patch_valid;
    assign o_patch_col      = r_out.patch_col;
    assign o_patch_tile     = r_out.patch_tile;
    assign o_last           = r_out.last;

endmodule
